// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on clk_i, with and without
// the reset qualifier.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk_i while rst_ni is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check prop at every rising edge of clk_i, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/smse_pkg.sv =====
// ---------------------------------------------------------------------------
// smse_pkg
// Widths, codes and payload types shared by the sample mean / error blocks.
// ---------------------------------------------------------------------------
package smse_pkg;

  localparam int COUNT_BITS = 16;
  localparam int SAMPLE_W   = 24;
  localparam int ERR_W      = 24;
  localparam int SUM_W      = SAMPLE_W + COUNT_BITS;
  localparam int SQ_W       = 64;
  localparam int SQP_W      = 2 * SAMPLE_W;
  localparam int VAR_W      = 2 * ERR_W;
  localparam int NUM_W      = COUNT_BITS + SQ_W;
  localparam int DEN_W      = 2 * COUNT_BITS;
  localparam int MPD_W      = SQ_W;
  localparam int MPR_W      = SUM_W;
  localparam int ACC_W      = (NUM_W > 2 * SUM_W) ? NUM_W : 2 * SUM_W;
  localparam int ITER_W     = $clog2(NUM_W);
  localparam int SR_W       = ERR_W + 2;
  localparam int JOB_DEPTH  = 2;  // power of two
  localparam int APB_AW     = 2;
  localparam int APB_DW     = 32;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [ERR_W-1:0]      ERR_MAX = '1;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_SINGLE = 2'd1;
  localparam logic [1:0] STATUS_OVF    = 2'd2;

  localparam logic [APB_AW-1:0] REG_JACKKNIFE = '0;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } smse_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean;
    logic [ERR_W-1:0]           error;
    logic [1:0]                 status;
  } smse_out_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sumsq;
    logic [COUNT_BITS-1:0]   count;
  } smse_job_t;

  typedef struct packed {
    logic      valid;
    smse_job_t job;
  } smse_job_wr_t;

  typedef struct packed {
    logic      valid;
    smse_job_t job;
  } smse_job_rd_t;

endpackage

// ===== rtl/smse_front.sv =====
// ---------------------------------------------------------------------------
// smse_front
// Sample intake: square each sample, accumulate sum, sum of squares and
// count, and hand a closed set to the job queue.
// ---------------------------------------------------------------------------
module smse_front import smse_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  smse_in_t     in_data_i,
  output logic         full_o,
  input  logic         job_full_i,
  output smse_job_wr_t job_wr_o
);

  logic                       st_v_q, st_v_d;
  logic signed [SAMPLE_W-1:0] st_s_q;
  logic [SQP_W-1:0]           st_sq_q;
  logic                       st_last_q;
  logic signed [SQP_W-1:0]    sq_prod;

  logic signed [SUM_W-1:0]    sum_q, sum_d, sum_nx;
  logic [SQ_W-1:0]            sumsq_q, sumsq_d, sumsq_nx;
  logic [COUNT_BITS-1:0]      cnt_q, cnt_d, cnt_nx;
  logic [SQ_W:0]              sq_add;
  logic                       take, advance, accept;

  assign sq_prod = in_data_i.sample * in_data_i.sample;

  assign advance = st_v_q & ~(st_last_q & job_full_i);
  assign full_o  = st_v_q & ~advance;
  assign accept  = push_i & ~full_o;

  always_comb begin
    st_v_d = st_v_q;
    if (accept) begin
      st_v_d = 1'b1;
    end else if (advance) begin
      st_v_d = 1'b0;
    end
  end

  // drop samples once the count is pinned at its maximum
  assign take   = (cnt_q != CNT_MAX);
  assign sq_add = {1'b0, sumsq_q} + (SQ_W+1)'(st_sq_q);

  always_comb begin
    sum_nx   = sum_q;
    sumsq_nx = sumsq_q;
    cnt_nx   = cnt_q;
    if (take) begin
      sum_nx   = sum_q + {{(SUM_W-SAMPLE_W){st_s_q[SAMPLE_W-1]}}, st_s_q};
      sumsq_nx = sq_add[SQ_W] ? '1 : sq_add[SQ_W-1:0];
      cnt_nx   = cnt_q + 1'b1;
    end
  end

  always_comb begin
    sum_d   = sum_q;
    sumsq_d = sumsq_q;
    cnt_d   = cnt_q;
    if (advance) begin
      if (st_last_q) begin
        sum_d   = '0;
        sumsq_d = '0;
        cnt_d   = '0;
      end else begin
        sum_d   = sum_nx;
        sumsq_d = sumsq_nx;
        cnt_d   = cnt_nx;
      end
    end
  end

  assign job_wr_o.valid     = advance & st_last_q;
  assign job_wr_o.job.sum   = sum_nx;
  assign job_wr_o.job.sumsq = sumsq_nx;
  assign job_wr_o.job.count = cnt_nx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q  <= 1'b0;
      sum_q   <= '0;
      sumsq_q <= '0;
      cnt_q   <= '0;
    end else begin
      st_v_q  <= st_v_d;
      sum_q   <= sum_d;
      sumsq_q <= sumsq_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_s_q    <= in_data_i.sample;
      st_sq_q   <= sq_prod;
      st_last_q <= in_data_i.last;
    end
  end

endmodule

// ===== rtl/smse_job_fifo.sv =====
// ---------------------------------------------------------------------------
// smse_job_fifo
// Short queue of closed sets between intake and the arithmetic back end.
// ---------------------------------------------------------------------------
module smse_job_fifo import smse_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  smse_job_wr_t job_wr_i,
  output logic         full_o,
  input  logic         pop_i,
  output smse_job_rd_t job_rd_o
);

  localparam int PTR_W = $clog2(JOB_DEPTH);

  smse_job_t        mem_q [JOB_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   fill_q, fill_d;
  logic             wr_en, rd_en;

  assign full_o = (fill_q == (PTR_W+1)'(JOB_DEPTH));
  assign wr_en  = job_wr_i.valid & ~full_o;
  assign rd_en  = pop_i & job_rd_o.valid;

  assign job_rd_o.valid = (fill_q != '0);
  assign job_rd_o.job   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q;
    if (wr_en && !rd_en) begin
      fill_d = fill_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= job_wr_i.job;
    end
  end

endmodule

// ===== rtl/smse_back.sv =====
// ---------------------------------------------------------------------------
// smse_back
// Per-set arithmetic: mean by shift-subtract division, the variance
// numerator and denominator by shift-add multiplication, the variance by
// a second division and the error by a digit-by-digit square root.
// ---------------------------------------------------------------------------
module smse_back import smse_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         jackknife_i,
  input  smse_job_rd_t job_rd_i,
  output logic         job_pop_o,
  input  logic         pop_i,
  output logic         empty_o,
  output smse_out_t    out_data_o
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MDIV = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_SUB  = 7'b0001000,
    ST_VDIV = 7'b0010000,
    ST_SQRT = 7'b0100000,
    ST_DONE = 7'b1000000
  } back_state_e;

  typedef enum logic [1:0] {
    MUL_DEN = 2'd0,
    MUL_A   = 2'd1,
    MUL_B   = 2'd2
  } mul_op_e;

  back_state_e state_q, state_d;
  mul_op_e     mul_op_q, mul_op_d;
  logic        out_v_q, out_v_d;

  logic [ITER_W-1:0]          cnt_q, cnt_d;
  logic                       neg_q, neg_d, ovf_q, ovf_d;
  logic [COUNT_BITS-1:0]      n_q, n_d;
  logic [SQ_W-1:0]            sumsq_q, sumsq_d;
  logic [SUM_W-1:0]           mag_q, mag_d;
  logic [DEN_W-1:0]           den_q, den_d;
  logic [NUM_W-1:0]           a_q, a_d;
  logic [ACC_W-1:0]           acc_q, acc_d;
  logic [MPD_W-1:0]           mpd_q, mpd_d;
  logic [MPR_W-1:0]           mpr_q, mpr_d;
  logic [NUM_W-1:0]           dvd_q, dvd_d;
  logic [DEN_W-1:0]           dvs_q, dvs_d, rem_q, rem_d;
  logic [VAR_W-1:0]           x_q, x_d;
  logic [ERR_W-1:0]           root_q, root_d, err_q, err_d;
  logic [SR_W-1:0]            srem_q, srem_d;
  logic signed [SAMPLE_W-1:0] mean_q, mean_d;
  smse_out_t                  out_q, out_d;

  // shift-subtract division step
  logic [DEN_W:0]    rem_sh, rem_sub;
  logic              div_ge;
  logic [DEN_W-1:0]  rem_nx;
  logic [NUM_W-1:0]  dvd_nx;
  // shift-add multiplication step
  logic [ACC_W-1:0]  acc_nx;
  logic [MPR_W-1:0]  mpr_nx;
  // variance numerator
  logic [ACC_W:0]    num_full;
  logic [NUM_W-1:0]  num;
  // square root step
  logic [SR_W+1:0]   sr_sh, sr_trial, sr_sub;
  logic              sq_ge;
  logic [SR_W-1:0]   srem_nx;
  logic [ERR_W-1:0]  root_nx;
  // job load
  logic [SUM_W-1:0]  job_mag;
  logic              job_neg;
  logic              cnt_zero;
  logic [SAMPLE_W-1:0] q_lo;

  assign rem_sh  = {rem_q, dvd_q[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign div_ge  = ~rem_sub[DEN_W];
  assign rem_nx  = div_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  assign dvd_nx  = {dvd_q[NUM_W-2:0], div_ge};

  assign acc_nx = {acc_q[ACC_W-2:0], 1'b0} + (mpr_q[MPR_W-1] ? ACC_W'(mpd_q) : '0);
  assign mpr_nx = {mpr_q[MPR_W-2:0], 1'b0};

  assign num_full = {1'b0, ACC_W'(a_q)} - {1'b0, acc_q};
  assign num      = num_full[ACC_W] ? '0 : num_full[NUM_W-1:0];

  assign sr_sh    = {srem_q, x_q[VAR_W-1 -: 2]};
  assign sr_trial = {2'b00, root_q, 2'b01};
  assign sr_sub   = sr_sh - sr_trial;
  assign sq_ge    = (sr_sh >= sr_trial);
  assign srem_nx  = sq_ge ? sr_sub[SR_W-1:0] : sr_sh[SR_W-1:0];
  assign root_nx  = {root_q[ERR_W-2:0], sq_ge};

  assign job_neg  = job_rd_i.job.sum[SUM_W-1];
  assign job_mag  = job_neg ? SUM_W'(0) - job_rd_i.job.sum : job_rd_i.job.sum;
  assign cnt_zero = (cnt_q == '0);
  assign q_lo     = dvd_nx[SAMPLE_W-1:0];

  assign job_pop_o  = (state_q == ST_IDLE) & job_rd_i.valid;
  assign empty_o    = ~out_v_q;
  assign out_data_o = out_q;

  always_comb begin
    state_d  = state_q;
    mul_op_d = mul_op_q;
    out_v_d  = out_v_q;
    cnt_d    = cnt_q;
    neg_d    = neg_q;
    ovf_d    = ovf_q;
    n_d      = n_q;
    sumsq_d  = sumsq_q;
    mag_d    = mag_q;
    den_d    = den_q;
    a_d      = a_q;
    acc_d    = acc_q;
    mpd_d    = mpd_q;
    mpr_d    = mpr_q;
    dvd_d    = dvd_q;
    dvs_d    = dvs_q;
    rem_d    = rem_q;
    x_d      = x_q;
    root_d   = root_q;
    srem_d   = srem_q;
    err_d    = err_q;
    mean_d   = mean_q;
    out_d    = out_q;

    if (pop_i) begin
      out_v_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (job_rd_i.valid) begin
          neg_d   = job_neg;
          mag_d   = job_mag;
          n_d     = job_rd_i.job.count;
          sumsq_d = job_rd_i.job.sumsq;
          ovf_d   = (job_rd_i.job.count == CNT_MAX) | (&job_rd_i.job.sumsq);
          dvd_d   = NUM_W'(job_mag);
          dvs_d   = DEN_W'(job_rd_i.job.count);
          rem_d   = '0;
          cnt_d   = ITER_W'(NUM_W - 1);
          state_d = ST_MDIV;
        end
      end
      ST_MDIV: begin
        dvd_d = dvd_nx;
        rem_d = rem_nx;
        cnt_d = cnt_q - 1'b1;
        if (cnt_zero) begin
          mean_d = neg_q ? SAMPLE_W'(0) - q_lo : q_lo;
          if (n_q < COUNT_BITS'(2)) begin
            err_d   = '0;
            state_d = ST_DONE;
          end else begin
            mul_op_d = MUL_DEN;
            acc_d    = '0;
            mpd_d    = jackknife_i ? MPD_W'(1) : MPD_W'(n_q - 1'b1);
            mpr_d    = MPR_W'(n_q);
            cnt_d    = ITER_W'(MPR_W - 1);
            state_d  = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        acc_d = acc_nx;
        mpr_d = mpr_nx;
        cnt_d = cnt_q - 1'b1;
        if (cnt_zero) begin
          cnt_d = ITER_W'(MPR_W - 1);
          case (mul_op_q)
            MUL_DEN: begin
              den_d    = acc_nx[DEN_W-1:0];
              acc_d    = '0;
              mpd_d    = sumsq_q;
              mpr_d    = MPR_W'(n_q);
              mul_op_d = MUL_A;
            end
            MUL_A: begin
              a_d      = acc_nx[NUM_W-1:0];
              acc_d    = '0;
              mpd_d    = MPD_W'(mag_q);
              mpr_d    = mag_q;
              mul_op_d = MUL_B;
            end
            default: begin
              state_d = ST_SUB;
            end
          endcase
        end
      end
      ST_SUB: begin
        // a negative numerator only follows a pinned square sum: clamp to zero
        dvd_d   = num;
        dvs_d   = den_q;
        rem_d   = '0;
        cnt_d   = ITER_W'(NUM_W - 1);
        state_d = ST_VDIV;
      end
      ST_VDIV: begin
        dvd_d = dvd_nx;
        rem_d = rem_nx;
        cnt_d = cnt_q - 1'b1;
        if (cnt_zero) begin
          if (|dvd_nx[NUM_W-1:VAR_W]) begin
            err_d   = ERR_MAX;
            ovf_d   = 1'b1;
            state_d = ST_DONE;
          end else begin
            x_d     = dvd_nx[VAR_W-1:0];
            root_d  = '0;
            srem_d  = '0;
            cnt_d   = ITER_W'(ERR_W - 1);
            state_d = ST_SQRT;
          end
        end
      end
      ST_SQRT: begin
        x_d    = {x_q[VAR_W-3:0], 2'b00};
        root_d = root_nx;
        srem_d = srem_nx;
        cnt_d  = cnt_q - 1'b1;
        if (cnt_zero) begin
          err_d   = root_nx;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_v_q || pop_i) begin
          out_d.mean  = mean_q;
          out_d.error = err_q;
          if (ovf_q) begin
            out_d.status = STATUS_OVF;
          end else if (n_q < COUNT_BITS'(2)) begin
            out_d.status = STATUS_SINGLE;
          end else begin
            out_d.status = STATUS_OK;
          end
          out_v_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mul_op_q <= MUL_DEN;
      out_v_q  <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      mul_op_q <= mul_op_d;
      out_v_q  <= out_v_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    ovf_q   <= ovf_d;
    n_q     <= n_d;
    sumsq_q <= sumsq_d;
    mag_q   <= mag_d;
    den_q   <= den_d;
    a_q     <= a_d;
    acc_q   <= acc_d;
    mpd_q   <= mpd_d;
    mpr_q   <= mpr_d;
    dvd_q   <= dvd_d;
    dvs_q   <= dvs_d;
    rem_q   <= rem_d;
    x_q     <= x_d;
    root_q  <= root_d;
    srem_q  <= srem_d;
    err_q   <= err_d;
    mean_q  <= mean_d;
    out_q   <= out_d;
  end

endmodule

// ===== rtl/sample_mean_std_error_unit.sv =====
// ---------------------------------------------------------------------------
// sample_mean_std_error_unit
// Streams signed Q.12 samples in sets and returns, per set, the mean and
// the standard-deviation error with a status code.
//
// Input queue side: drive in_data_i with push; a beat moves when push is
// high and full is low. in_data_i.last closes the current set.
// Result queue side: a result waits on out_data_o while empty is low and
// leaves when pop is high. One result per set, in set order.
// Intake takes one sample per cycle while full is low. Each closed set
// goes into a two-entry job queue; the back end works one set at a time
// (two 80-step divisions, three 40-step multiplications, a 24-step
// square root; a single-sample set needs only the first division).
// The shift-subtract divider sets the pace of the back end.
// When pop stays low, the finished result holds and the back end waits
// with the next one; the job queue then fills and full rises on the next
// set-closing beat, while samples inside a set still stream.
// Reset clears the accumulators, the queues and jackknife_mode.
// Configuration: APB register 0 (byte address 0) holds jackknife_mode.
// ---------------------------------------------------------------------------
module sample_mean_std_error_unit import smse_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // sample queue
  input  logic              push,
  output logic              full,
  input  smse_in_t          in_data_i,
  // result queue
  output logic              empty,
  input  logic              pop,
  output smse_out_t         out_data_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic         jackknife_q, jackknife_d;
  logic         cfg_wr;
  smse_job_wr_t job_wr;
  smse_job_rd_t job_rd;
  logic         job_full;
  logic         job_pop;

  // ---- configuration register ----
  // pready stays high: every access completes in its access cycle
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    jackknife_d = jackknife_q;
    // drop writes to addresses that hold no register
    if (cfg_wr && (paddr == REG_JACKKNIFE)) begin
      jackknife_d = pwdata[0];
    end
  end

  assign prdata = (paddr == REG_JACKKNIFE) ? APB_DW'(jackknife_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jackknife_q <= 1'b0;
    end else begin
      jackknife_q <= jackknife_d;
    end
  end

  // ---- front: square and accumulate, one sample per cycle while full is low ----
  smse_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_data_i  (in_data_i),
    .full_o     (full),
    .job_full_i (job_full),
    .job_wr_o   (job_wr)
  );

  // ---- job queue: decouples intake from the arithmetic ----
  smse_job_fifo u_job_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .job_wr_i (job_wr),
    .full_o   (job_full),
    .pop_i    (job_pop),
    .job_rd_o (job_rd)
  );

  // ---- back: mean, variance, root and the result register ----
  smse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .jackknife_i (jackknife_q),
    .job_rd_i    (job_rd),
    .job_pop_o   (job_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/smse_checker.sv =====
// ---------------------------------------------------------------------------
// smse_checker
// Port-level checks on the result queue of the mean / error unit.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module smse_checker import smse_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input smse_out_t out_data_o
);

  // skip the first edge: the result valid flag only settles once reset is seen
  `ASSERT_ALWAYS(a_reset_empty,
                 (!rst_ni && $past(!rst_ni)) |-> empty,
                 "result queue not empty in reset")

  `ASSERT_CLK(a_stall_hold,
              (!empty && !pop) |=> (!empty && $stable(out_data_o)),
              "stalled beat changed")

  `ASSERT_CLK(a_status_code,
              !empty |-> (out_data_o.status <= STATUS_OVF),
              "undefined status")

  `ASSERT_CLK(a_single_zero,
              (!empty && out_data_o.status == STATUS_SINGLE) |-> (out_data_o.error == '0),
              "single-sample set with nonzero error")

endmodule

bind sample_mean_std_error_unit smse_checker u_smse_checker (.*);
